// File: src/cccu_pkg.sv
// Shared types, constants and calendar helper functions for the calendar
// clock counter unit. No dependencies.
`default_nettype none

package cccu_pkg;

  localparam int YEAR_W   = 16;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int FIELD_W  = 8;

  localparam logic [YEAR_W-1:0]   YEAR_MIN    = 16'd2000;
  localparam logic [MONTH_W-1:0]  MONTH_MIN   = 4'd1;
  localparam logic [MONTH_W-1:0]  MONTH_MAX   = 4'd12;
  localparam logic [MONTH_W-1:0]  MONTH_FEB   = 4'd2;
  localparam logic [DAY_W-1:0]    DAY_MIN     = 5'd1;
  localparam logic [DAY_W-1:0]    DAY_DEFAULT = 5'd31;
  localparam logic [HOUR_W-1:0]   HOUR_MAX    = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX  = 6'd59;
  localparam logic [SECOND_W-1:0] SECOND_MAX  = 6'd59;

  // Reset time
  localparam logic [YEAR_W-1:0]   RST_YEAR   = 16'd2024;
  localparam logic [MONTH_W-1:0]  RST_MONTH  = 4'd10;
  localparam logic [DAY_W-1:0]    RST_DAY    = 5'd26;
  localparam logic [HOUR_W-1:0]   RST_HOUR   = 5'd11;
  localparam logic [MINUTE_W-1:0] RST_MINUTE = 6'd28;
  localparam logic [SECOND_W-1:0] RST_SECOND = 6'd30;

  // Divisibility by 25: multiply by the inverse of 25 modulo 2^16, then the
  // value is a multiple of 25 exactly when the product is at most 65535/25.
  localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_LIM = 16'd2621;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } cal_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    prod  = y * INV25;
    div25 = (prod[YEAR_W-1:0] <= DIV25_LIM);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0]  y,
                                                  input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] idx;
    logic [DAY_W-1:0]   len;
    idx = m - MONTH_MIN;
    if ((m < MONTH_MIN) || (m > MONTH_MAX)) begin
      len = DAY_DEFAULT;
    end else if (m == MONTH_FEB) begin
      len = MONTH_LEN[1] + {{(DAY_W-1){1'b0}}, is_leap(y)};
    end else begin
      len = MONTH_LEN[idx];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// File: src/calendar_clock_counter_unit.sv
// Top level of the calendar clock counter: input register, load and tick
// logic, time registers that double as the result register.
// Depends on cccu_pkg, cccu_load_clamp and cccu_tick_adv.
//
// Usage:
//   Input channel (in_valid / in_stall): each item is a one-second tick
//   (in_op = 0) or a load of a new date and time (in_op = 1). A load is
//   clamped into range; out_load_valid reports whether no clamping was needed.
//   Result channel (out_valid / out_stall): one item per input item, giving
//   the time after that item. out_load_valid is 0 for ticks.
//   Configuration: cfg_wr_en writes cfg_wr_data into the paused bit; while
//   paused, ticks leave the time unchanged but still produce a result.
//   Throughput: one item per clock while no result is held. An accepted
//   item moves from the input register into the time registers, which drive
//   the result channel; these form two stages with a combinational carry chain.
//   Reset: time returns to 2024-10-26 11:28:30, paused clears, both stages
//   empty.
//   Stall: a held result keeps the time registers frozen; one more item
//   waits in the input register, then in_stall rises until out_stall drops.
`default_nettype none

module calendar_clock_counter_unit import cccu_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_op,
  input  wire logic [YEAR_W-1:0]   in_new_year,
  input  wire logic [FIELD_W-1:0]  in_new_month,
  input  wire logic [FIELD_W-1:0]  in_new_day,
  input  wire logic [FIELD_W-1:0]  in_new_hour,
  input  wire logic [FIELD_W-1:0]  in_new_minute,
  input  wire logic [FIELD_W-1:0]  in_new_second,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [YEAR_W-1:0]        out_cur_year,
  output logic [MONTH_W-1:0]       out_cur_month,
  output logic [DAY_W-1:0]         out_cur_day,
  output logic [HOUR_W-1:0]        out_cur_hour,
  output logic [MINUTE_W-1:0]      out_cur_minute,
  output logic [SECOND_W-1:0]      out_cur_second,
  output logic                     out_load_valid,
  // configuration
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_wr_data
);

  // input register
  logic               in_vld_r;
  logic               in_op_r;
  logic [YEAR_W-1:0]  in_year_r;
  logic [FIELD_W-1:0] in_month_r, in_day_r, in_hour_r, in_minute_r, in_second_r;

  // time state, also the result payload
  cal_t cal_r, cal_nxt;
  logic load_valid_r, load_valid_nxt;
  logic out_vld_r;
  logic paused_r;

  cal_t load_cal, tick_cal;
  logic load_ok;
  logic step;

  cccu_load_clamp u_load (
    .new_year   (in_year_r),
    .new_month  (in_month_r),
    .new_day    (in_day_r),
    .new_hour   (in_hour_r),
    .new_minute (in_minute_r),
    .new_second (in_second_r),
    .clamped    (load_cal),
    .load_ok    (load_ok)
  );

  // time registers are always in range, so the tick path needs no pre-clamp
  cccu_tick_adv u_tick (
    .cur (cal_r),
    .adv (tick_cal)
  );

  // advance the held item into the result stage when that stage frees up
  assign step     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !step;

  always_comb begin
    if (in_op_r) begin
      cal_nxt        = load_cal;
      load_valid_nxt = load_ok;
    end else begin
      cal_nxt        = paused_r ? cal_r : tick_cal;
      load_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  // capture payload only on accept
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op_r     <= in_op;
      in_year_r   <= in_new_year;
      in_month_r  <= in_new_month;
      in_day_r    <= in_new_day;
      in_hour_r   <= in_new_hour;
      in_minute_r <= in_new_minute;
      in_second_r <= in_new_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r        <= '{year: RST_YEAR, month: RST_MONTH, day: RST_DAY,
                        hour: RST_HOUR, minute: RST_MINUTE, second: RST_SECOND};
      load_valid_r <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (step) begin
        cal_r        <= cal_nxt;
        load_valid_r <= load_valid_nxt;
        out_vld_r    <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paused_r <= 1'b0;
    end else if (cfg_wr_en) begin
      paused_r <= cfg_wr_data;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_cur_year   = cal_r.year;
  assign out_cur_month  = cal_r.month;
  assign out_cur_day    = cal_r.day;
  assign out_cur_hour   = cal_r.hour;
  assign out_cur_minute = cal_r.minute;
  assign out_cur_second = cal_r.second;
  assign out_load_valid = load_valid_r;

  // stall only while an item is held in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("in_stall raised with empty input register");

  // a running tick always moves the seconds
  a_tick_moves: assert property (@(posedge clk) disable iff (!rst_n)
    step && !in_op_r && !paused_r |=> cal_r.second != $past(cal_r.second))
    else $error("unpaused tick left seconds unchanged");

  // ticks never report a valid load
  a_tick_no_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    step && !in_op_r |=> !load_valid_r)
    else $error("load_valid set on a tick");

  // stored date stays in range
  a_date_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cal_r.month >= MONTH_MIN) && (cal_r.month <= MONTH_MAX) && (cal_r.day != '0)
    && (cal_r.year >= YEAR_MIN))
    else $error("stored date out of range");

endmodule

`default_nettype wire

// File: src/cccu_load_clamp.sv
// Load path: checks a supplied date and time and clamps it into range.
// Depends on cccu_pkg.
`default_nettype none

module cccu_load_clamp import cccu_pkg::*; (
  input  wire logic [YEAR_W-1:0]  new_year,
  input  wire logic [FIELD_W-1:0] new_month,
  input  wire logic [FIELD_W-1:0] new_day,
  input  wire logic [FIELD_W-1:0] new_hour,
  input  wire logic [FIELD_W-1:0] new_minute,
  input  wire logic [FIELD_W-1:0] new_second,
  output cal_t                    clamped,
  output logic                    load_ok
);

  logic             year_ok, month_ok, day_ok, hour_ok, minute_ok, second_ok;
  logic [DAY_W-1:0] max_day;

  always_comb begin
    year_ok   = (new_year >= YEAR_MIN);
    clamped.year = year_ok ? new_year : YEAR_MIN;

    month_ok  = 1'b0;
    if (new_month == '0) begin
      clamped.month = MONTH_MIN;
    end else if (new_month > FIELD_W'(MONTH_MAX)) begin
      clamped.month = MONTH_MAX;
    end else begin
      clamped.month = new_month[MONTH_W-1:0];
      month_ok      = 1'b1;
    end

    // month length from the already clamped year and month
    max_day = month_days(clamped.year, clamped.month);
    day_ok  = 1'b0;
    if (new_day == '0) begin
      clamped.day = DAY_MIN;
    end else if (new_day > FIELD_W'(max_day)) begin
      clamped.day = max_day;
    end else begin
      clamped.day = new_day[DAY_W-1:0];
      day_ok      = 1'b1;
    end

    hour_ok        = (new_hour <= FIELD_W'(HOUR_MAX));
    clamped.hour   = hour_ok ? new_hour[HOUR_W-1:0] : HOUR_MAX;
    minute_ok      = (new_minute <= FIELD_W'(MINUTE_MAX));
    clamped.minute = minute_ok ? new_minute[MINUTE_W-1:0] : MINUTE_MAX;
    second_ok      = (new_second <= FIELD_W'(SECOND_MAX));
    clamped.second = second_ok ? new_second[SECOND_W-1:0] : SECOND_MAX;

    load_ok = year_ok && month_ok && day_ok && hour_ok && minute_ok && second_ok;
  end

endmodule

`default_nettype wire

// File: src/cccu_tick_adv.sv
// Tick path: advances an in-range calendar time by one second with carries.
// Depends on cccu_pkg.
`default_nettype none

module cccu_tick_adv import cccu_pkg::*; (
  input  wire cal_t cur,
  output cal_t      adv
);

  logic [DAY_W-1:0]  max_day;
  logic [YEAR_W-1:0] year_inc;

  always_comb begin
    max_day  = month_days(cur.year, cur.month);
    year_inc = cur.year + 1'b1;
    adv      = cur;
    if (cur.second >= SECOND_MAX) begin
      adv.second = '0;
      if (cur.minute >= MINUTE_MAX) begin
        adv.minute = '0;
        if (cur.hour >= HOUR_MAX) begin
          adv.hour = '0;
          if (cur.day >= max_day) begin
            adv.day = DAY_MIN;
            if (cur.month >= MONTH_MAX) begin
              adv.month = MONTH_MIN;
              // wrap past the top year lands below the floor: hold at floor
              adv.year  = (year_inc < YEAR_MIN) ? YEAR_MIN : year_inc;
            end else begin
              adv.month = cur.month + 1'b1;
            end
          end else begin
            adv.day = cur.day + 1'b1;
          end
        end else begin
          adv.hour = cur.hour + 1'b1;
        end
      end else begin
        adv.minute = cur.minute + 1'b1;
      end
    end else begin
      adv.second = cur.second + 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_calendar_clock_counter_unit.sv
// Self-checking testbench for calendar_clock_counter_unit: a directed table, then random
// load and tick sequences, all scored against a calendar predictor kept inside the bench.
// Depends on cccu_pkg and calendar_clock_counter_unit.

module tb_calendar_clock_counter_unit;
  import cccu_pkg::*;

  // Run limits. Worst case per item is the longest sender gap plus the longest result
  // stall over ~1200 items; the limit is several times that.
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int          HOLD_CYCLES = 48;
  localparam int          PLAN_ROWS   = 25;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } clock_op_t;

  // One result item as the block reports it.
  typedef struct packed {
    cal_t t;
    logic lv;
  } clock_reading_t;

  // Calendar fields widened so that clamping sees the raw load values.
  typedef struct packed {
    logic [31:0] y;
    logic [31:0] mo;
    logic [31:0] d;
    logic [31:0] h;
    logic [31:0] mi;
    logic [31:0] s;
  } wide_cal_t;

  typedef struct packed {
    logic           paused;
    clock_op_t      op;
    logic [15:0]    y;
    logic [7:0]     mo;
    logic [7:0]     d;
    logic [7:0]     h;
    logic [7:0]     mi;
    logic [7:0]     s;
    logic           typed;
    clock_reading_t want;
  } plan_row_t;

  // Directed rows: extremes, every leap-year branch, every carry level, year wrap,
  // clamping of each field, ticks and loads while paused. Rows with typed = 1 carry
  // a hand-written expectation; the rest are scored by the predictor.
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // tick right after reset
    '{0, OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1,
      '{'{2024, 10, 26, 11, 28, 31}, 0}},
    // every field at its maximum: clamps to the last second of year 65535
    '{0, OP_LOAD, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1,
      '{'{65535, 12, 31, 23, 59, 59}, 0}},
    // year carry past 65535 comes back as 2000
    '{0, OP_TICK, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1,
      '{'{2000, 1, 1, 0, 0, 0}, 0}},
    // every field at its minimum
    '{0, OP_LOAD, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1,
      '{'{2000, 1, 1, 0, 0, 0}, 0}},
    // leap day of a year divisible by 400
    '{0, OP_LOAD, 16'd2000, 8'd2, 8'd29, 8'd23, 8'd59, 8'd59, 1,
      '{'{2000, 2, 29, 23, 59, 59}, 1}},
    '{0, OP_TICK, 16'h5A5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hA5, 1,
      '{'{2000, 3, 1, 0, 0, 0}, 0}},
    // year below 2000 clamps up
    '{0, OP_LOAD, 16'd1999, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, 1,
      '{'{2000, 12, 31, 23, 59, 59}, 0}},
    '{0, OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1,
      '{'{2001, 1, 1, 0, 0, 0}, 0}},
    // day clamp uses the clamped year: 2000 is leap, so the 29th survives
    '{0, OP_LOAD, 16'd1900, 8'd2, 8'd29, 8'd12, 8'd0, 8'd0, 1,
      '{'{2000, 2, 29, 12, 0, 0}, 0}},
    // century year that is not leap
    '{0, OP_LOAD, 16'd2100, 8'd2, 8'd29, 8'd12, 8'd0, 8'd0, 1,
      '{'{2100, 2, 28, 12, 0, 0}, 0}},
    '{0, OP_LOAD, 16'd2100, 8'd2, 8'd28, 8'd23, 8'd59, 8'd59, 0, '0},
    '{0, OP_TICK, 16'hFFFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 0, '0},
    // ordinary leap year
    '{0, OP_LOAD, 16'd2024, 8'd2, 8'd28, 8'd23, 8'd59, 8'd59, 0, '0},
    '{0, OP_TICK, 16'h0000, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 0, '0},
    // 31st of a 30-day month
    '{0, OP_LOAD, 16'd2024, 8'd4, 8'd31, 8'd10, 8'd30, 8'd0, 1,
      '{'{2024, 4, 30, 10, 30, 0}, 0}},
    // month, day, hour, minute and second each just outside its range
    '{0, OP_LOAD, 16'd2024, 8'd13, 8'd0, 8'd24, 8'd60, 8'd60, 1,
      '{'{2024, 12, 1, 23, 59, 59}, 0}},
    '{0, OP_LOAD, 16'd2400, 8'd2, 8'd29, 8'd0, 8'd0, 8'd59, 0, '0},
    '{0, OP_TICK, 16'h1234, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 0, '0},
    '{0, OP_LOAD, 16'd2023, 8'd6, 8'd30, 8'd23, 8'd59, 8'd59, 0, '0},
    '{0, OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, '0},
    // load while paused still applies
    '{1, OP_LOAD, 16'd2030, 8'd5, 8'd15, 8'd10, 8'd20, 8'd30, 1,
      '{'{2030, 5, 15, 10, 20, 30}, 1}},
    // tick while paused holds the time
    '{1, OP_TICK, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1,
      '{'{2030, 5, 15, 10, 20, 30}, 0}},
    '{1, OP_LOAD, 16'd65535, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, 1,
      '{'{65535, 12, 31, 23, 59, 59}, 1}},
    '{1, OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1,
      '{'{65535, 12, 31, 23, 59, 59}, 0}},
    // unpaused again: wrap from the held time
    '{0, OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1,
      '{'{2000, 1, 1, 0, 0, 0}, 0}}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_op;
  logic [YEAR_W-1:0]   in_new_year;
  logic [FIELD_W-1:0]  in_new_month;
  logic [FIELD_W-1:0]  in_new_day;
  logic [FIELD_W-1:0]  in_new_hour;
  logic [FIELD_W-1:0]  in_new_minute;
  logic [FIELD_W-1:0]  in_new_second;
  logic                out_valid;
  logic                out_stall;
  logic [YEAR_W-1:0]   out_cur_year;
  logic [MONTH_W-1:0]  out_cur_month;
  logic [DAY_W-1:0]    out_cur_day;
  logic [HOUR_W-1:0]   out_cur_hour;
  logic [MINUTE_W-1:0] out_cur_minute;
  logic [SECOND_W-1:0] out_cur_second;
  logic                out_load_valid;
  logic                cfg_wr_en;
  logic                cfg_wr_data;

  // Predictor state: the clock as the block should hold it, plus the paused bit.
  cal_t           now_cal;
  logic           paused_now;
  clock_reading_t pending_readings [$];
  int unsigned    mismatch_count = 0;
  int unsigned    items_sent = 0;

  // Sideband from the sender to the scoreboard for the item now on the input port.
  logic           pend_typed = 1'b0;
  clock_reading_t pend_want = '0;

  // Idling controls shared between the sender, the receiver and the sequence.
  logic sender_idles = 1'b1;
  logic quiet_rx = 1'b0;
  logic hold_req = 1'b0;

  calendar_clock_counter_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_new_year    (in_new_year),
    .in_new_month   (in_new_month),
    .in_new_day     (in_new_day),
    .in_new_hour    (in_new_hour),
    .in_new_minute  (in_new_minute),
    .in_new_second  (in_new_second),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cur_year   (out_cur_year),
    .out_cur_month  (out_cur_month),
    .out_cur_day    (out_cur_day),
    .out_cur_hour   (out_cur_hour),
    .out_cur_minute (out_cur_minute),
    .out_cur_second (out_cur_second),
    .out_load_valid (out_load_valid),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------------------

  function automatic logic [31:0] days_in(input logic [31:0] y, input logic [31:0] m);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:            days_in = leap ? 29 : 28;
      4, 6, 9, 11:  days_in = 30;
      default:      days_in = 31;  // also covers months out of range
    endcase
  endfunction

  // Pull every field into range; the day limit comes from the already clamped year/month.
  function automatic wide_cal_t clamp_cal(input wide_cal_t w);
    logic [31:0] top;
    if (w.y < 2000) w.y = 2000;
    if (w.mo < 1) w.mo = 1;
    if (w.mo > 12) w.mo = 12;
    top = days_in(w.y, w.mo);
    if (w.d < 1) w.d = 1;
    if (w.d > top) w.d = top;
    if (w.h > 23) w.h = 23;
    if (w.mi > 59) w.mi = 59;
    if (w.s > 59) w.s = 59;
    return w;
  endfunction

  // Apply one accepted item to the predicted clock and return the reading it yields.
  function automatic clock_reading_t advance_clock(input logic op, input logic [15:0] ny,
                                                   input logic [7:0] nmo, input logic [7:0] nd,
                                                   input logic [7:0] nh, input logic [7:0] nmi,
                                                   input logic [7:0] ns);
    wide_cal_t      w;
    clock_reading_t r;
    logic           ok;
    ok = 1'b0;
    if (op == OP_LOAD) begin
      w.y = ny; w.mo = nmo; w.d = nd; w.h = nh; w.mi = nmi; w.s = ns;
      ok = (w.y >= 2000) && (w.mo >= 1) && (w.mo <= 12) && (w.d >= 1) &&
           (w.d <= days_in(w.y, w.mo)) && (w.h <= 23) && (w.mi <= 59) && (w.s <= 59);
      w = clamp_cal(w);
    end else begin
      w.y = now_cal.year; w.mo = now_cal.month; w.d = now_cal.day;
      w.h = now_cal.hour; w.mi = now_cal.minute; w.s = now_cal.second;
      if (!paused_now) begin
        w = clamp_cal(w);
        // ripple the carry from seconds up to the year
        w.s = w.s + 1;
        if (w.s >= 60) begin
          w.s = 0;
          w.mi = w.mi + 1;
          if (w.mi >= 60) begin
            w.mi = 0;
            w.h = w.h + 1;
            if (w.h >= 24) begin
              w.h = 0;
              w.d = w.d + 1;
              if (w.d > days_in(w.y, w.mo)) begin
                w.d = 1;
                w.mo = w.mo + 1;
                if (w.mo > 12) begin
                  w.mo = 1;
                  w.y = (w.y + 1) & 32'h0000_FFFF;
                  if (w.y < 2000) w.y = 2000;
                end
              end
            end
          end
        end
      end
    end
    now_cal.year   = w.y[YEAR_W-1:0];
    now_cal.month  = w.mo[MONTH_W-1:0];
    now_cal.day    = w.d[DAY_W-1:0];
    now_cal.hour   = w.h[HOUR_W-1:0];
    now_cal.minute = w.mi[MINUTE_W-1:0];
    now_cal.second = w.s[SECOND_W-1:0];
    r.t  = now_cal;
    r.lv = ok;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Scoreboard: everything is sampled on the rising edge, before the block updates.
  // Score a leaving result first, then queue the prediction for an arriving item, so an
  // item taken on the same edge never lines up with its own result.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    clock_reading_t got;
    clock_reading_t want;
    if (!rst_n) begin
      now_cal    = '{16'd2024, 4'd10, 5'd26, 5'd11, 6'd28, 6'd30};
      paused_now = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.t  = '{out_cur_year, out_cur_month, out_cur_day, out_cur_hour,
                   out_cur_minute, out_cur_second};
        got.lv = out_load_valid;
        if (pending_readings.size() == 0) begin
          $display("%0t: expected no item, got %0d-%0d-%0d %0d:%0d:%0d load_valid %0d",
                   $time, got.t.year, got.t.month, got.t.day, got.t.hour, got.t.minute,
                   got.t.second, got.lv);
          mismatch_count++;
        end else begin
          want = pending_readings.pop_front();
          check_field("cur_year", want.t.year, got.t.year);
          check_field("cur_month", want.t.month, got.t.month);
          check_field("cur_day", want.t.day, got.t.day);
          check_field("cur_hour", want.t.hour, got.t.hour);
          check_field("cur_minute", want.t.minute, got.t.minute);
          check_field("cur_second", want.t.second, got.t.second);
          check_field("load_valid", want.lv, got.lv);
        end
      end
      if (cfg_wr_en) paused_now = cfg_wr_data;
      if (in_valid && !in_stall) begin
        // advance the predictor always; a typed row overrides what gets scored
        want = advance_clock(in_op, in_new_year, in_new_month, in_new_day, in_new_hour,
                             in_new_minute, in_new_second);
        if (pend_typed) want = pend_want;
        pending_readings.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result-side back pressure: random stall bursts, one long hold on request, none once the
  // run goes quiet. Drive on the falling edge.
  // ---------------------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // hold off long enough for both stages to fill and in_stall to rise
        out_stall = 1'b1;
        for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(negedge clk);
        hold_req  = 1'b0;
        out_stall = 1'b0;
      end else if (!quiet_rx && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Bound the run; a lost or stuck result ends here.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("calendar_clock_counter_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Sender helpers. All drive on the falling edge and return on a falling edge.
  // ---------------------------------------------------------------------------------------

  // Offer one item, with an optional random gap ahead of it, and hold it until taken.
  task automatic offer(input clock_op_t op, input logic [15:0] y, input logic [7:0] mo,
                       input logic [7:0] d, input logic [7:0] h, input logic [7:0] mi,
                       input logic [7:0] s, input logic typed, input clock_reading_t want);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_op         = op;
    in_new_year   = y;
    in_new_month  = mo;
    in_new_day    = d;
    in_new_hour   = h;
    in_new_minute = mi;
    in_new_second = s;
    pend_typed    = typed;
    pend_want     = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has been scored.
  task automatic drain;
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
  endtask

  // Write the paused bit only once the block is idle.
  task automatic set_paused(input logic v);
    drain();
    repeat (2) @(negedge clk);
    cfg_wr_data = v;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // One random phase: mostly a load just short of a rollover followed by a burst of
  // ticks, mixed with fully random loads and lone ticks with junk payloads.
  task automatic run_phase(input int n, input logic paused_v, input logic idles,
                           input logic quiet, input logic with_hold);
    logic [31:0] y, mo, d, h, mi, s, top;
    int          burst;
    int unsigned start;
    logic        hold_pending;
    set_paused(paused_v);
    sender_idles = idles;
    quiet_rx     = quiet;
    hold_pending = with_hold;
    start        = items_sent;
    while (items_sent - start < n) begin
      if (hold_pending && items_sent - start >= 100) begin
        hold_req     = 1'b1;
        hold_pending = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          // noise load: every payload bit random
          offer(OP_LOAD, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 1'b0, '0);
        end
        2: begin
          offer(OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 1'b0, '0);
        end
        default: begin
          case ($urandom_range(0, 7))
            0:       y = 65535;
            1:       y = 2000 + 100 * $urandom_range(0, 4);
            2:       y = $urandom_range(2000, 65535);
            default: y = $urandom_range(2000, 2103);
          endcase
          mo  = $urandom_range(1, 12);
          top = days_in(y, mo);
          d   = ($urandom_range(0, 1) != 0) ? top : $urandom_range(1, top);
          h   = ($urandom_range(0, 1) != 0) ? 23 : $urandom_range(0, 23);
          mi  = ($urandom_range(0, 1) != 0) ? 59 : $urandom_range(0, 59);
          s   = $urandom_range(50, 59);
          // now and then bump the day by one, past month end when it was the last day
          if ($urandom_range(0, 7) == 0) d = d + 1;
          offer(OP_LOAD, y[15:0], mo[7:0], d[7:0], h[7:0], mi[7:0], s[7:0], 1'b0, '0);
          for (burst = $urandom_range(1, 8); burst > 0; burst--) begin
            offer(OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 1'b0, '0);
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------
  initial begin : sequencer
    logic paused_set;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_TICK;
    in_new_year   = '0;
    in_new_month  = '0;
    in_new_day    = '0;
    in_new_hour   = '0;
    in_new_minute = '0;
    in_new_second = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed table; change the paused bit only between drained rows.
    set_paused(1'b0);
    paused_set = 1'b0;
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (DIRECTED_PLAN[i].paused != paused_set) begin
        set_paused(DIRECTED_PLAN[i].paused);
        paused_set = DIRECTED_PLAN[i].paused;
      end
      offer(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].y, DIRECTED_PLAN[i].mo, DIRECTED_PLAN[i].d,
            DIRECTED_PLAN[i].h, DIRECTED_PLAN[i].mi, DIRECTED_PLAN[i].s,
            DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
    end

    // Random phases: alternate the paused bit, vary idling, end with no idling at all.
    run_phase(320, 1'b0, 1'b1, 1'b0, 1'b1);
    run_phase(130, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(300, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(120, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(300, 1'b0, 1'b0, 1'b1, 1'b0);

    // Let the last results out, then keep the clock running so anything stray is seen.
    drain();
    repeat (8) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("calendar_clock_counter_unit: match");
    end else begin
      $display("calendar_clock_counter_unit: mismatch");
    end
    $finish;
  end

endmodule
